// ----- rtl/sfcc_pkg.sv -----
// Shared types and the CRC-8 step for the sensor frame checker.
`default_nettype none

package sfcc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte slot inside one word: two data bytes, then the CRC byte.
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    localparam logic KIND_MEAS  = 1'b0;
    localparam logic KIND_READY = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       mode;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  bad_word;
        logic        frame_kind;
        logic [31:0] co2_bits;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic        data_ready;
    } out_word_t;

    // One byte through the MSB-first CRC-8 register.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sensor_frame_crc_checker.sv -----
// Sensor response frame checker: per-word CRC-8 check and raw word assembly.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one received byte per
//   transfer, with frame_start on the first byte of a frame and mode giving the
//   frame kind (measurement: WORDS_PER_FRAME words, data-ready: one word).
//   Each frame word is two data bytes, high first, then its CRC-8 byte.
//   Output channel out_valid/out_ready/out_data carries one result on the
//   last byte of a frame: CRC status, first bad word, kind, the three raw
//   32-bit float words (measurement) or the data-ready flag.
//   Throughput: one byte per cycle while in_ready is high; the CRC byte
//   step is a single combinational update of the frame CRC register.
//   Latency: the result is valid the cycle after the last byte is accepted.
//   A stalled receiver holds the result register; in_ready stays high as
//   long as the result register is empty or being drained this cycle.
//   Reset clears position, error tracking and the assembled words and sets the CRC to its initial value.
//   Bytes after a completed frame are dropped until the next frame_start;
//   a frame_start in mid-frame abandons the frame without a result.
`default_nettype none

module sensor_frame_crc_checker #(
    parameter int WORDS_PER_FRAME = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sfcc_pkg::in_word_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sfcc_pkg::out_word_t    out_data
);

    localparam int WW = $clog2(WORDS_PER_FRAME + 1);

    logic [WW-1:0] word_reg, word_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    crc_reg, crc_next;
    logic          kind_reg, kind_next;
    logic          err_reg, err_next;
    logic [2:0]    first_bad_reg, first_bad_next;
    logic [31:0]   co2_reg, co2_next;
    logic [31:0]   temp_reg, temp_next;
    logic [31:0]   hum_reg, hum_next;

    logic                 out_valid_reg, out_valid_next;
    sfcc_pkg::out_word_t  out_reg, out_next;

    logic          accept;
    logic [WW-1:0] cur_word;
    logic [1:0]    cur_phase;
    logic [7:0]    cur_crc;
    logic          cur_kind;
    logic          cur_err;
    logic [2:0]    cur_first;
    logic [WW-1:0] nwords;
    logic          active;
    logic          last_byte;
    logic [WW+2:0] word_ext;
    logic [WW+1:0] pair_idx;
    logic [7:0]    b;
    logic [7:0]    crc_step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign b         = in_data.rx_byte;
    assign crc_step  = sfcc_pkg::crc8_byte(cur_crc, b);

    always_comb
    begin
        // frame_start restarts the frame with this byte
        if (in_data.frame_start)
        begin
            cur_word  = '0;
            cur_phase = sfcc_pkg::PH_HIGH;
            cur_crc   = sfcc_pkg::CRC_INIT;
            cur_kind  = in_data.mode;
            cur_err   = 1'b0;
            cur_first = 3'd0;
        end
        else
        begin
            cur_word  = word_reg;
            cur_phase = phase_reg;
            cur_crc   = crc_reg;
            cur_kind  = kind_reg;
            cur_err   = err_reg;
            cur_first = first_bad_reg;
        end

        nwords    = (cur_kind == sfcc_pkg::KIND_READY) ? WW'(1) : WW'(WORDS_PER_FRAME);
        active    = cur_word < nwords;
        word_ext  = {3'b000, cur_word};
        pair_idx  = word_ext[WW+2:1];
        last_byte = active && (cur_phase == sfcc_pkg::PH_CRC)
                    && ((cur_word + WW'(1)) == nwords);

        word_next      = cur_word;
        phase_next     = cur_phase;
        crc_next       = cur_crc;
        kind_next      = cur_kind;
        err_next       = cur_err;
        first_bad_next = cur_first;
        co2_next       = co2_reg;
        temp_next      = temp_reg;
        hum_next       = hum_reg;

        if (active)
        begin
            if (cur_phase == sfcc_pkg::PH_CRC)
            begin
                if (b != cur_crc && !cur_err)
                begin
                    err_next       = 1'b1;
                    first_bad_next = word_ext[2:0];
                end
                crc_next   = sfcc_pkg::CRC_INIT;
                phase_next = sfcc_pkg::PH_HIGH;
                word_next  = cur_word + WW'(1);
            end
            else
            begin
                crc_next   = crc_step;
                phase_next = cur_phase + 2'd1;
                // even word fills the upper half, high byte goes first
                unique case ({word_ext[0], cur_phase == sfcc_pkg::PH_HIGH})
                    2'b01:   begin
                        if (pair_idx == (WW+2)'(0)) co2_next[31:24]  = b;
                        if (pair_idx == (WW+2)'(1)) temp_next[31:24] = b;
                        if (pair_idx == (WW+2)'(2)) hum_next[31:24]  = b;
                    end
                    2'b00:   begin
                        if (pair_idx == (WW+2)'(0)) co2_next[23:16]  = b;
                        if (pair_idx == (WW+2)'(1)) temp_next[23:16] = b;
                        if (pair_idx == (WW+2)'(2)) hum_next[23:16]  = b;
                    end
                    2'b11:   begin
                        if (pair_idx == (WW+2)'(0)) co2_next[15:8]  = b;
                        if (pair_idx == (WW+2)'(1)) temp_next[15:8] = b;
                        if (pair_idx == (WW+2)'(2)) hum_next[15:8]  = b;
                    end
                    default: begin
                        if (pair_idx == (WW+2)'(0)) co2_next[7:0]  = b;
                        if (pair_idx == (WW+2)'(1)) temp_next[7:0] = b;
                        if (pair_idx == (WW+2)'(2)) hum_next[7:0]  = b;
                    end
                endcase
            end
        end

        out_next            = out_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        if (accept && last_byte)
        begin
            out_valid_next            = 1'b1;
            out_next.status           = err_next;
            out_next.bad_word         = first_bad_next;
            out_next.frame_kind       = cur_kind;
            if (cur_kind == sfcc_pkg::KIND_MEAS)
            begin
                out_next.co2_bits         = co2_next;
                out_next.temperature_bits = temp_next;
                out_next.humidity_bits    = hum_next;
                out_next.data_ready       = 1'b0;
            end
            else
            begin
                out_next.co2_bits         = '0;
                out_next.temperature_bits = '0;
                out_next.humidity_bits    = '0;
                out_next.data_ready       = !err_next && (co2_next[31:16] == 16'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            phase_reg     <= sfcc_pkg::PH_HIGH;
            crc_reg       <= sfcc_pkg::CRC_INIT;
            kind_reg      <= sfcc_pkg::KIND_MEAS;
            err_reg       <= 1'b0;
            first_bad_reg <= 3'd0;
            co2_reg       <= '0;
            temp_reg      <= '0;
            hum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                word_reg      <= word_next;
                phase_reg     <= phase_next;
                crc_reg       <= crc_next;
                kind_reg      <= kind_next;
                err_reg       <= err_next;
                first_bad_reg <= first_bad_next;
                co2_reg       <= co2_next;
                temp_reg      <= temp_next;
                hum_reg       <= hum_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // A clean frame never reports a bad word index.
    a_clean_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status || out_data.bad_word == 3'd0))
        else $error("bad_word set without a CRC error");

    // Data-ready flag only on a clean data-ready frame.
    a_ready_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.data_ready) |->
            (out_data.frame_kind == sfcc_pkg::KIND_READY && !out_data.status))
        else $error("data_ready on wrong frame kind or with CRC error");

    // Data-ready results carry no float words; the check covers the CO2 and humidity words.
    a_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_kind == sfcc_pkg::KIND_READY) |->
            (out_data.co2_bits == 32'd0 && out_data.humidity_bits == 32'd0))
        else $error("float words leaked into data-ready result");

    // Byte slot never reaches the unused code.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("byte slot out of range");

    // An accepted frame start latches the frame kind.
    a_kind_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.frame_start) |=> (kind_reg == $past(in_data.mode)))
        else $error("frame kind not taken at frame start");

endmodule

`default_nettype wire
